[rtl/gbr_pkg.sv]
// shared types and constants of the 3x3 rgba gaussian blur
`timescale 1ns / 1ps
package gbr_pkg;

	// field widths of the stream and the configuration port
	localparam int CHAN_W       = 8;
	localparam int ROW_W        = 16;
	localparam int COL_W        = 11;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// register values after reset
	localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// input beat
	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] alpha_in;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] alpha_out;
		logic [ROW_W-1:0]  out_row;
		logic [COL_W-1:0]  out_column;
		logic              last_of_image;
	} out_beat_t;

	// one pixel, red in the low byte
	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	// one image column at the input position: two rows up, one row up, current
	typedef struct packed {
		pixel_t older;
		pixel_t recent;
		pixel_t current;
	} column_t;

	// classified pixel handed from front to back
	typedef struct packed {
		column_t          pixels;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             emit;
		logic             last_row;
		logic             last_col;
		logic             has_older;
		logic             left_is_window;
	} col_entry_t;

endpackage

[rtl/gbr_cfg.sv]
// configuration registers and clamped image limits
`timescale 1ns / 1ps
module gbr_cfg #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gbr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [gbr_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic [$clog2(MAX_WIDTH)-1:0]         width_last,
	output logic [gbr_pkg::ROW_W-1:0]            height_last
);
	import gbr_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = (AW + 1 > CFG_WIDTH_W) ? AW + 1 : CFG_WIDTH_W;

	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	logic [CW-1:0]           w_ext;
	logic [CW-1:0]           w_lim;
	logic [CFG_HEIGHT_W-1:0] h_lim;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[CFG_HEIGHT_W-1:0];
			endcase
		end
	end

	// width clamped to 2..MAX_WIDTH, height to at least 2
	always_comb begin
		w_ext = CW'(image_width_q);
		if (w_ext < CW'(2))
			w_lim = CW'(2);
		else if (w_ext > CW'(MAX_WIDTH))
			w_lim = CW'(MAX_WIDTH);
		else
			w_lim = w_ext;
		h_lim = (image_height_q < CFG_HEIGHT_W'(2)) ? CFG_HEIGHT_W'(2) : image_height_q;
	end

	assign width_last  = AW'(w_lim - CW'(1));
	assign height_last = ROW_W'(h_lim - CFG_HEIGHT_W'(1));

endmodule

[rtl/gbr_front.sv]
// front end: raster counters, line stores and classification of each pixel
`timescale 1ns / 1ps
module gbr_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  gbr_pkg::in_beat_t             pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]  width_last,
	input  logic [gbr_pkg::ROW_W-1:0]     height_last,
	input  logic [gbr_pkg::QCNT_W-1:0]    q_count,
	output logic                          push,
	output gbr_pkg::col_entry_t           push_entry
);
	import gbr_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	typedef struct packed {
		pixel_t older;
		pixel_t recent;
	} line_word_t;

	logic             accept;
	logic             last_col;
	logic             last_row;
	logic [QCNT_W-1:0] fill;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	pixel_t           pix_in;

	logic             valid_s1;
	pixel_t           pix_s1;
	logic [AW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             emit_s1;
	logic             last_row_s1;
	logic             last_col_s1;
	logic             has_older_s1;
	logic             left_win_s1;
	line_word_t       rd_s1;

	line_word_t       line_mem [MAX_WIDTH];

	// room for the beat in flight and the one taken now
	assign fill        = q_count + QCNT_W'(valid_s1);
	assign pixel_stall = fill >= QCNT_W'(QUEUE_DEPTH);
	assign accept      = pixel_valid && !pixel_stall;

	assign last_col = col_q >= width_last;
	assign last_row = row_q >= height_last;

	always_comb begin
		pix_in.red   = pixel.red_in;
		pix_in.green = pixel.green_in;
		pix_in.blue  = pixel.blue_in;
		pix_in.alpha = pixel.alpha_in;
	end

	// raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pix_in;
			col_s1       <= col_q;
			row_s1       <= row_q;
			emit_s1      <= (row_q != '0) && (col_q != '0);
			last_row_s1  <= last_row;
			last_col_s1  <= last_col;
			has_older_s1 <= row_q >= ROW_W'(2);
			left_win_s1  <= col_q >= AW'(2);
		end
	end

	// line stores: read the column on accept, shift it up one row in the next cycle
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[col_q];
		if (valid_s1)
			line_mem[col_s1] <= '{older: rd_s1.recent, recent: pix_s1};
	end

	// hand the classified column to the queue
	assign push = valid_s1;
	always_comb begin
		push_entry.pixels.older    = rd_s1.older;
		push_entry.pixels.recent   = rd_s1.recent;
		push_entry.pixels.current  = pix_s1;
		push_entry.row             = row_s1;
		push_entry.column          = COL_W'(col_s1);
		push_entry.emit            = emit_s1;
		push_entry.last_row        = last_row_s1;
		push_entry.last_col        = last_col_s1;
		push_entry.has_older       = has_older_s1;
		push_entry.left_is_window  = left_win_s1;
	end

	// the write-back of a column never hits the column read in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 |-> col_q != col_s1)
		else $error("line store read and write at the same column");

endmodule

[rtl/gbr_queue.sv]
// short queue of classified columns between front and back
`timescale 1ns / 1ps
module gbr_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  gbr_pkg::col_entry_t         push_entry,
	input  logic                        pop,
	output logic                        head_valid,
	output gbr_pkg::col_entry_t         head,
	output logic [gbr_pkg::QCNT_W-1:0]  q_count
);
	import gbr_pkg::*;

	col_entry_t        store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= push_entry;
	end

	assign head       = store_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign q_count    = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("column queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("column queue underflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("column queue count out of step");

endmodule

[rtl/gbr_back.sv]
// back end: 3x3 window, mirrored borders, kernel sum and output register
`timescale 1ns / 1ps
module gbr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  gbr_pkg::col_entry_t  head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output gbr_pkg::out_beat_t   result
);
	import gbr_pkg::*;

	// result sequence for one column
	localparam logic [1:0] SLOT_UPPER_LEFT  = 2'd0;
	localparam logic [1:0] SLOT_LOWER_LEFT  = 2'd1;
	localparam logic [1:0] SLOT_UPPER_RIGHT = 2'd2;
	localparam logic [1:0] SLOT_LOWER_RIGHT = 2'd3;

	// kernel weights 1, 2, 4 over 16 as right shifts
	localparam int SH_CORNER = 4;
	localparam int SH_EDGE   = 3;
	localparam int SH_CENTER = 2;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} tap_col_t;

	// vertical taps for a result one row above the input row
	function automatic tap_col_t upper(column_t v, logic has_older);
		tap_col_t t;
		t.top = has_older ? v.older : v.current;
		t.mid = v.recent;
		t.bot = v.current;
		return t;
	endfunction

	// vertical taps for a result on the bottom row
	function automatic tap_col_t lower(column_t v);
		tap_col_t t;
		t.top = v.recent;
		t.mid = v.current;
		t.bot = v.recent;
		return t;
	endfunction

	// each tap truncated on its own, then summed per channel
	function automatic pixel_t blur3(tap_col_t l, tap_col_t m, tap_col_t r);
		logic [31:0] lt, lm, lb, mt, mm, mb, rt, rm, rb;
		logic [31:0] res;
		logic [9:0]  sum;
		lt = l.top;
		lm = l.mid;
		lb = l.bot;
		mt = m.top;
		mm = m.mid;
		mb = m.bot;
		rt = r.top;
		rm = r.mid;
		rb = r.bot;
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			sum = 10'(lt[8*ch +: 8] >> SH_CORNER) + 10'(lm[8*ch +: 8] >> SH_EDGE)
			    + 10'(lb[8*ch +: 8] >> SH_CORNER) + 10'(mt[8*ch +: 8] >> SH_EDGE)
			    + 10'(mm[8*ch +: 8] >> SH_CENTER) + 10'(mb[8*ch +: 8] >> SH_EDGE)
			    + 10'(rt[8*ch +: 8] >> SH_CORNER) + 10'(rm[8*ch +: 8] >> SH_EDGE)
			    + 10'(rb[8*ch +: 8] >> SH_CORNER);
			res[8*ch +: 8] = sum[7:0];
		end
		return pixel_t'(res);
	endfunction

	logic             out_ready;
	logic             produce;
	logic             more;
	logic [1:0]       slot_q;
	logic [1:0]       next_slot;
	column_t          win_a_q;
	column_t          win_b_q;
	column_t          left;
	tap_col_t         tap_l;
	tap_col_t         tap_m;
	tap_col_t         tap_r;
	pixel_t           blurred;
	logic [ROW_W-1:0] res_row;
	logic [COL_W-1:0] res_col;
	logic             res_last;
	logic             result_valid_q;
	out_beat_t        result_q;

	assign out_ready = !result_valid_q || !result_stall;
	assign produce   = head_valid && head.emit && out_ready;
	assign pop       = head_valid && (!head.emit || (out_ready && !more));

	// the left column mirrors onto the right one at the first column
	assign left = head.left_is_window ? win_a_q : head.pixels;

	// window taps and position for the current result
	always_comb begin
		unique case (slot_q)
			SLOT_UPPER_LEFT: begin
				tap_l    = upper(left, head.has_older);
				tap_m    = upper(win_b_q, head.has_older);
				tap_r    = upper(head.pixels, head.has_older);
				res_row  = head.row - ROW_W'(1);
				res_col  = head.column - COL_W'(1);
				res_last = 1'b0;
			end
			SLOT_LOWER_LEFT: begin
				tap_l    = lower(left);
				tap_m    = lower(win_b_q);
				tap_r    = lower(head.pixels);
				res_row  = head.row;
				res_col  = head.column - COL_W'(1);
				res_last = 1'b0;
			end
			SLOT_UPPER_RIGHT: begin
				tap_l    = upper(win_b_q, head.has_older);
				tap_m    = upper(head.pixels, head.has_older);
				tap_r    = upper(win_b_q, head.has_older);
				res_row  = head.row - ROW_W'(1);
				res_col  = head.column;
				res_last = 1'b0;
			end
			SLOT_LOWER_RIGHT: begin
				tap_l    = lower(win_b_q);
				tap_m    = lower(head.pixels);
				tap_r    = lower(win_b_q);
				res_row  = head.row;
				res_col  = head.column;
				res_last = 1'b1;
			end
		endcase
	end

	assign blurred = blur3(tap_l, tap_m, tap_r);

	// next result of this column, if any
	always_comb begin
		next_slot = SLOT_UPPER_LEFT;
		more      = 1'b0;
		unique case (slot_q)
			SLOT_UPPER_LEFT: begin
				if (head.last_row) begin
					next_slot = SLOT_LOWER_LEFT;
					more      = 1'b1;
				end else if (head.last_col) begin
					next_slot = SLOT_UPPER_RIGHT;
					more      = 1'b1;
				end
			end
			SLOT_LOWER_LEFT: begin
				if (head.last_col) begin
					next_slot = SLOT_UPPER_RIGHT;
					more      = 1'b1;
				end
			end
			SLOT_UPPER_RIGHT: begin
				if (head.last_row) begin
					next_slot = SLOT_LOWER_RIGHT;
					more      = 1'b1;
				end
			end
			SLOT_LOWER_RIGHT: begin
				more = 1'b0;
			end
		endcase
	end

	// sequencer, window shift and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q         <= SLOT_UPPER_LEFT;
			win_a_q        <= '0;
			win_b_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				result_valid_q <= produce;
			if (pop) begin
				slot_q  <= SLOT_UPPER_LEFT;
				win_a_q <= win_b_q;
				win_b_q <= head.pixels;
			end else if (produce) begin
				slot_q <= next_slot;
			end
		end
	end

	// output beat
	always_ff @(posedge clk) begin
		if (produce) begin
			result_q.red_out       <= blurred.red;
			result_q.green_out     <= blurred.green;
			result_q.blue_out      <= blurred.blue;
			result_q.alpha_out     <= blurred.alpha;
			result_q.out_row       <= res_row;
			result_q.out_column    <= res_col;
			result_q.last_of_image <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a column part way through its results stays at the head of the queue
	a_hold_head: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != SLOT_UPPER_LEFT |-> head_valid && head.emit)
		else $error("multi-beat column left the queue early");

	// the last beat of an image only comes from the bottom-right column
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		produce && res_last |-> head.last_row && head.last_col)
		else $error("end of image flagged away from the corner");

endmodule

[rtl/gaussian_blur_3x3_rgba_top.sv]
// 3x3 gaussian blur of an rgba raster stream, top level
// Takes one RGBA pixel per clock in raster order and returns each channel filtered with
// [1 2 1; 2 4 2; 1 2 1]/16, every tap truncated on its own before the sum, with the image
// mirrored at its borders. Each result carries its row and column and last_of_image flags
// the bottom-right pixel. The result for pixel (r-1, c-1) leaves when pixel (r, c) arrives;
// the last column and the whole bottom row leave when their final input pixel arrives, so
// the first row and column of input produce nothing on their own. While the receiver
// does not stall, a pixel is taken every clock as long as each pixel causes at most one
// result, and the back end puts out one result per clock; a last-column pixel causes two
// results, a bottom-row pixel two and the bottom-right pixel four, while the four-entry
// column queue absorbs the input. Two line stores live in one memory of MAX_WIDTH words
// of 64 bits with one read and one write port; the width and height registers may only
// be written while no pixel is in flight.
`timescale 1ns / 1ps
module gaussian_blur_3x3_rgba_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  gbr_pkg::in_beat_t                pixel,
	output logic                             result_valid,
	input  logic                             result_stall,
	output gbr_pkg::out_beat_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gbr_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [AW-1:0]     width_last;
	logic [ROW_W-1:0]  height_last;
	logic [QCNT_W-1:0] q_count;
	logic              push;
	col_entry_t        push_entry;
	logic              pop;
	logic              head_valid;
	col_entry_t        head;

	// configuration registers
	gbr_cfg #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.width_last (width_last),
		.height_last(height_last)
	);

	// pixel intake and line stores
	gbr_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.width_last (width_last),
		.height_last(height_last),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	// column queue
	gbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.q_count   (q_count)
	);

	// filter and output
	gbr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

[tb/tb.sv]
// self-checking testbench for the 3x3 rgba gaussian blur: directed images, register clamps, random images
`timescale 1ns / 1ps
module tb;
	import gbr_pkg::*;

	localparam int MAX_W         = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_LIMIT     = 5000;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int MAX_PRINTS    = 30;

	// column of three pixels, index 0 is the top row
	typedef logic [2:0][31:0] trip_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   pixel_valid  = 1'b0;
	logic                   pixel_stall;
	in_beat_t               pixel        = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_beat_t              result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	// shadow of the block: line stores, window, counters, registers
	logic [31:0]       older_store  [MAX_W];
	logic [31:0]       recent_store [MAX_W];
	trip_t             win_left;
	trip_t             win_mid;
	logic [15:0]       row_cnt;
	int unsigned       col_cnt;
	logic [11:0]       reg_width;
	logic [15:0]       reg_height;
	out_beat_t         blurred_q [$];

	int src_idle_pct    = 0;
	int sink_stall_pct  = 0;
	int mismatches      = 0;
	int results_checked = 0;
	int pixels_sent     = 0;
	int images_done     = 0;

	gaussian_blur_3x3_rgba_top #(
		.MAX_WIDTH(MAX_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// one mismatch line, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	// weighted sum of nine taps, each tap truncated on its own
	function automatic logic [31:0] blur_pixel(trip_t l, trip_t m, trip_t r);
		logic [31:0] res;
		int unsigned sum;
		int          wy;
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			sum = 0;
			for (int y = 0; y < 3; y++) begin
				wy = (y == 1) ? 2 : 1;
				sum += (int'(l[y][8*ch +: 8]) * wy) >> 4;
				sum += (int'(m[y][8*ch +: 8]) * wy * 2) >> 4;
				sum += (int'(r[y][8*ch +: 8]) * wy) >> 4;
			end
			res[8*ch +: 8] = sum[7:0];
		end
		return res;
	endfunction

	// vertical taps for a result one row above the input row; top row mirrors
	function automatic trip_t upper_trip(trip_t v, logic has_older);
		trip_t t;
		t[0] = has_older ? v[0] : v[2];
		t[1] = v[1];
		t[2] = v[2];
		return t;
	endfunction

	// vertical taps for a result in the bottom row; row below mirrors
	function automatic trip_t lower_trip(trip_t v);
		trip_t t;
		t[0] = v[1];
		t[1] = v[2];
		t[2] = v[1];
		return t;
	endfunction

	task automatic push_blurred(logic [31:0] px, logic [15:0] row, int unsigned col, logic last);
		out_beat_t e;
		e.red_out       = px[7:0];
		e.green_out     = px[15:8];
		e.blue_out      = px[23:16];
		e.alpha_out     = px[31:24];
		e.out_row       = row;
		e.out_column    = col[COL_W-1:0];
		e.last_of_image = last;
		blurred_q.push_back(e);
	endtask

	// expected results caused by one accepted pixel
	task automatic filter_pixel(in_beat_t p);
		int unsigned w, h, c;
		logic [15:0] r;
		logic [31:0] cur;
		trip_t       colc, left, a, b;
		logic        lastcol, lastrow, has_older;
		w = 32'(reg_width);
		if (w < 2) w = 2;
		if (w > MAX_W) w = MAX_W;
		h = 32'(reg_height);
		if (h < 2) h = 2;
		r = row_cnt;
		c = col_cnt;
		if (c >= MAX_W) c = MAX_W - 1;
		cur = {p.alpha_in, p.blue_in, p.green_in, p.red_in};

		// column at the input position, then shift the line stores
		colc[0] = older_store[c];
		colc[1] = recent_store[c];
		colc[2] = cur;
		older_store[c]  = colc[1];
		recent_store[c] = cur;
		a = win_left;
		b = win_mid;
		lastcol   = (c >= w - 1);
		lastrow   = (r >= h - 1);
		has_older = (r >= 2);

		if (r >= 1 && c >= 1) begin
			left = (c >= 2) ? a : colc;
			push_blurred(blur_pixel(upper_trip(left, has_older), upper_trip(b, has_older),
				upper_trip(colc, has_older)), r - 16'd1, c - 1, 1'b0);
			if (lastrow) begin
				push_blurred(blur_pixel(lower_trip(left), lower_trip(b), lower_trip(colc)),
					r, c - 1, 1'b0);
			end
			// right edge mirrors the column to the left
			if (lastcol) begin
				push_blurred(blur_pixel(upper_trip(b, has_older), upper_trip(colc, has_older),
					upper_trip(b, has_older)), r - 16'd1, c, 1'b0);
				if (lastrow) begin
					push_blurred(blur_pixel(lower_trip(b), lower_trip(colc), lower_trip(b)),
						r, c, 1'b1);
				end
			end
		end

		win_left = b;
		win_mid  = colc;
		if (lastcol) begin
			col_cnt = 0;
			row_cnt = lastrow ? 16'd0 : r + 16'd1;
			if (lastrow) images_done++;
		end else begin
			col_cnt = c + 1;
		end
		pixels_sent++;
	endtask

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic in_beat_t rand_pixel();
		in_beat_t p;
		p.red_in   = rand_channel();
		p.green_in = rand_channel();
		p.blue_in  = rand_channel();
		p.alpha_in = rand_channel();
		return p;
	endfunction

	function automatic in_beat_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] a);
		in_beat_t p;
		p.red_in   = r;
		p.green_in = g;
		p.blue_in  = b;
		p.alpha_in = a;
		return p;
	endfunction

	// one input beat; called and returns at a falling edge
	task automatic send_pixel(in_beat_t p);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel       <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		filter_pixel(p);
		@(negedge clk);
	endtask

	// hold the sender until every expected result is out
	task automatic wait_for_results();
		pixel_valid <= 1'b0;
		do @(negedge clk); while (blurred_q.size() != 0);
	endtask

	// register write once the block has gone quiet
	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH) begin
			reg_width = data[CFG_WIDTH_W-1:0];
		end else begin
			reg_height = data;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_image(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		cfg_write(REG_IMAGE_WIDTH, w);
		cfg_write(REG_IMAGE_HEIGHT, h);
	endtask

	// random pixels up to the end of the current image, with an optional drain pause
	task automatic send_image(int pause_at);
		int k;
		k = 0;
		do begin
			if (k == pause_at) wait_for_results();
			send_pixel(rand_pixel());
			k++;
		end while (row_cnt != 0 || col_cnt != 0);
	endtask

	// smallest image: only the last pixel produces results, all four at once
	task automatic test_corner_image();
		set_image(16'd2, 16'd2);
		send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00));
		send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 8'hFF));
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// 3x3 of saturated and empty channels, including the largest sum
	task automatic test_extreme_values();
		set_image(16'd3, 16'd3);
		for (int i = 0; i < 9; i++) begin
			send_pixel(mk_pixel(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF,
				(i < 5) ? 8'hFF : 8'h00, (i >= 5) ? 8'hFF : 8'h01));
		end
	endtask

	// out-of-range register values clamp; width ignores the upper data bits
	task automatic test_register_clamps();
		set_image(16'd0, 16'd0);
		send_image(-1);
		set_image(16'd1, 16'd1);
		send_image(-1);
		set_image(16'hF003, 16'd3);
		send_image(-1);
	endtask

	// height cut below the current row, and width cut inside a row
	task automatic test_config_mid_image();
		set_image(16'd3, 16'hFFFF);
		repeat (15) send_pixel(rand_pixel());
		cfg_write(REG_IMAGE_HEIGHT, 16'd1);
		send_image(-1);
		set_image(16'd8, 16'd4);
		repeat (13) send_pixel(rand_pixel());
		cfg_write(REG_IMAGE_WIDTH, 16'd3);
		send_image(-1);
	endtask

	// random small images under each idle mix
	task automatic test_random_images();
		int n, w, h, pause_at;
		bit first;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
				default: begin src_idle_pct = 12; sink_stall_pct = 12; end
			endcase
			n = 0;
			first = 1'b1;
			while (n < 40) begin
				case ($urandom_range(0, 9))
					0: w = $urandom_range(33, 100);
					1, 2: w = $urandom_range(9, 32);
					default: w = $urandom_range(2, 8);
				endcase
				if (w > 32) h = 2;
				else h = $urandom_range(2, 5);
				set_image({4'($urandom), 12'(w)}, 16'(h));
				if (first) pause_at = (w * h) / 2;
				else if ($urandom_range(0, 3) == 0) pause_at = $urandom_range(0, w * h - 1);
				else pause_at = -1;
				send_image(pause_at);
				n += w * h;
				first = 1'b0;
			end
		end
		src_idle_pct   = 0;
		sink_stall_pct = 0;
	endtask

	// receiver stall
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic compare_field(string name, int unsigned got, int unsigned want, out_beat_t e);
		if (got != want) begin
			report_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
				name, e.out_row, e.out_column, got, want));
		end
	endtask

	// result beat against the oldest expectation
	always @(posedge clk) begin : check_results
		out_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (blurred_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat row %0d col %0d",
					result.out_row, result.out_column));
			end else begin
				want = blurred_q.pop_front();
				results_checked++;
				compare_field("red", 32'(result.red_out), 32'(want.red_out), want);
				compare_field("green", 32'(result.green_out), 32'(want.green_out), want);
				compare_field("blue", 32'(result.blue_out), 32'(want.blue_out), want);
				compare_field("alpha", 32'(result.alpha_out), 32'(want.alpha_out), want);
				compare_field("row", 32'(result.out_row), 32'(want.out_row), want);
				compare_field("column", 32'(result.out_column), 32'(want.out_column), want);
				compare_field("last", 32'(result.last_of_image), 32'(want.last_of_image),
					want);
			end
		end
	end

	// hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", blurred_q.size());
		$display("gaussian_blur_3x3_rgba_top regression: fail");
		$finish;
	end

	initial begin : run
		int guard;
		for (int i = 0; i < MAX_W; i++) begin
			older_store[i]  = '0;
			recent_store[i] = '0;
		end
		win_left   = '0;
		win_mid    = '0;
		row_cnt    = '0;
		col_cnt    = 0;
		reg_width  = IMAGE_WIDTH_RST;
		reg_height = IMAGE_HEIGHT_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_image();
		test_extreme_values();
		test_register_clamps();
		test_config_mid_image();
		test_random_images();

		// drain, then let the pipeline settle
		pixel_valid <= 1'b0;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (blurred_q.size() != 0 && guard < END_LIMIT);
		if (blurred_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", blurred_q.size()));
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("ran %0d images, %0d pixels in, %0d blurred pixels checked",
			images_done, pixels_sent, results_checked);
		$display("widths 2..100 with clamped registers, mid-image register cuts, four idle mixes");
		if (mismatches == 0) begin
			$display("gaussian_blur_3x3_rgba_top regression: pass");
		end else begin
			$display("gaussian_blur_3x3_rgba_top regression: fail");
		end
		$finish;
	end

endmodule
